### rtl/dpfr_pkg.sv
// shared types and constants of the dual protocol frame receiver
package dpfr_pkg;

  localparam int TEXT_CAPACITY = 64;
  localparam int TEXT_DEPTH    = TEXT_CAPACITY - 1;
  localparam int POS_W         = $clog2(TEXT_CAPACITY);
  localparam int PAIR_LENGTH   = 2;
  localparam int TICK_W        = 16;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]        BIN_HEADER    = 8'hFF;
  localparam logic [7:0]        BIN_FOOTER    = 8'hFE;
  localparam logic [7:0]        TXT_HEADER    = 8'h40;
  localparam logic [7:0]        TXT_CR        = 8'h0D;
  localparam logic [7:0]        TXT_LF        = 8'h0A;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(100);

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PAIR  = 2'd1,
    OP_DRAIN = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       a;
    logic [7:0]       b;
    logic [POS_W-1:0] pos;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     head_valid;
    q_entry_t head;
    logic     full;
  } q_status_t;

endpackage

### rtl/dpfr_front.sv
// front end: frame parser, tick timeout and timeout register
module dpfr_front import dpfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        accept,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  output q_push_t     qp
);

  typedef enum logic [4:0] {
    F_IDLE     = 5'b00001,
    F_BIN_DATA = 5'b00010,
    F_BIN_FOOT = 5'b00100,
    F_TXT_DATA = 5'b01000,
    F_TXT_LF   = 5'b10000
  } front_state_t;

  front_state_t      state, state_next;
  logic [POS_W-1:0]  fill, fill_next;
  logic [TICK_W-1:0] elapsed, elapsed_next;
  logic [TICK_W-1:0] timeout_ticks;
  logic [7:0]        pair_a, pair_b;

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    elapsed_next = elapsed;
    qp           = '0;
    qp.entry.op  = OP_WRITE;
    if (accept && cmd == CMD_TICK) begin
      if (elapsed != {TICK_W{1'b1}}) elapsed_next = elapsed + TICK_W'(1);
      if (state != F_IDLE && elapsed_next > timeout_ticks) state_next = F_IDLE;
    end else if (accept) begin
      elapsed_next = '0;
      case (state)
        F_BIN_DATA: begin
          fill_next = fill + POS_W'(1);
          if (fill_next >= POS_W'(PAIR_LENGTH)) state_next = F_BIN_FOOT;
        end
        F_BIN_FOOT: begin
          if (rx_byte == BIN_FOOTER) begin
            qp.push     = 1'b1;
            qp.entry.op = OP_PAIR;
            qp.entry.a  = pair_a;
            qp.entry.b  = pair_b;
          end
          state_next = F_IDLE;
        end
        F_TXT_DATA: begin
          if (rx_byte == TXT_CR) begin
            state_next = F_TXT_LF;
          end else if (fill < POS_W'(TEXT_DEPTH)) begin
            qp.push      = 1'b1;
            qp.entry.op  = OP_WRITE;
            qp.entry.a   = rx_byte;
            qp.entry.pos = fill;
            fill_next    = fill + POS_W'(1);
          end
        end
        F_TXT_LF: begin
          if (rx_byte == TXT_LF) begin
            qp.push      = 1'b1;
            qp.entry.op  = OP_DRAIN;
            qp.entry.pos = fill;
          end
          state_next = F_IDLE;
        end
        default: begin
          state_next = F_IDLE;
          if (rx_byte == BIN_HEADER) begin
            state_next = F_BIN_DATA;
            fill_next  = '0;
          end else if (rx_byte == TXT_HEADER) begin
            state_next = F_TXT_DATA;
            fill_next  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      fill          <= '0;
      elapsed       <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      elapsed <= elapsed_next;
      if (cfg_write) timeout_ticks <= cfg_data;
    end
  end

  // payload bytes of a binary frame
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_BYTE && state == F_BIN_DATA) begin
      if (fill == POS_W'(0)) pair_a <= rx_byte;
      else if (fill == POS_W'(1)) pair_b <= rx_byte;
    end
  end

endmodule

### rtl/dpfr_queue.sv
// short job queue between parser and result sequencer
module dpfr_queue import dpfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_push_t   qp,
  input  logic      pop,
  output q_status_t qs
);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign do_push = qp.push && !qs.full;
  assign do_pop  = pop && qs.head_valid;

  assign qs.head_valid = count != '0;
  assign qs.full       = count == QCNT_W'(QUEUE_DEPTH);
  assign qs.head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= qp.entry;
  end

endmodule

### rtl/dpfr_back.sv
// back end: text store and result sequencer with output register
module dpfr_back import dpfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  q_status_t        qs,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             frame_kind,
  output logic [7:0]       pair_first,
  output logic [7:0]       pair_second,
  output logic [7:0]       text_char,
  output logic [POS_W-1:0] text_position,
  output logic             last_of_run
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_EMIT = 3'b100
  } back_state_t;

  back_state_t      state;
  logic [7:0]       text_mem [TEXT_DEPTH];
  logic [7:0]       rdata;
  logic [POS_W-1:0] len, cnt;
  logic             out_free;
  logic             load_pair, load_char, load_nul, start_drain, mem_write;

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    load_pair   = 1'b0;
    load_char   = 1'b0;
    load_nul    = 1'b0;
    start_drain = 1'b0;
    mem_write   = 1'b0;
    pop         = 1'b0;
    case (state)
      B_IDLE: begin
        if (qs.head_valid) begin
          case (qs.head.op)
            OP_WRITE: begin
              mem_write = 1'b1;
              pop       = 1'b1;
            end
            OP_PAIR: begin
              load_pair = out_free;
              pop       = out_free;
            end
            OP_DRAIN: begin
              start_drain = 1'b1;
              pop         = 1'b1;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      B_READ: load_nul = (cnt == len) && out_free;
      B_EMIT: load_char = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (load_pair || load_char || load_nul) result_valid <= 1'b1;
      case (state)
        B_IDLE:  if (start_drain) state <= B_READ;
        B_READ: begin
          if (cnt != len) state <= B_EMIT;
          else if (load_nul) state <= B_IDLE;
        end
        B_EMIT:  if (load_char) state <= B_READ;
        default: state <= B_IDLE;
      endcase
    end
  end

  // drain counters and text store
  always_ff @(posedge clk) begin
    if (start_drain) begin
      len <= qs.head.pos;
      cnt <= '0;
    end else if (load_char) begin
      cnt <= cnt + POS_W'(1);
    end
    if (mem_write) text_mem[qs.head.pos] <= qs.head.a;
    rdata <= text_mem[cnt];
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_pair) begin
      frame_kind    <= KIND_PAIR;
      pair_first    <= qs.head.a;
      pair_second   <= qs.head.b;
      text_char     <= '0;
      text_position <= '0;
      last_of_run   <= 1'b1;
    end else if (load_char || load_nul) begin
      frame_kind    <= KIND_TEXT;
      pair_first    <= '0;
      pair_second   <= '0;
      text_char     <= load_char ? rdata : 8'h00;
      text_position <= cnt;
      last_of_run   <= load_nul;
    end
  end

endmodule

### rtl/dual_protocol_frame_receiver.sv
// top level of the dual protocol frame receiver
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    cmd, rx_byte
//  result    out        result_valid / result_stall frame_kind, pair_first, pair_second,
//                                                   text_char, text_position, last_of_run
//  config    in         cfg_write                  cfg_data (timeout_ticks)
//
// the parser takes one beat per cycle while the job queue has room; each byte queues
// at most one job (store a character, send a pair, or drain the text store)
// a pair result passes the job queue and then the output register after its footer beat
// a text drain alternates a read and an emit state for each character (registered text
// store read), so a long frame backs up the queue and then stalls the item channel
// rst is synchronous and active high; it empties the queue and returns to idle
// the result register is refilled only when empty or being taken, so result_stall
// holds every result in place
module dual_protocol_frame_receiver import dpfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [15:0]      cfg_data,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic             cmd,
  input  logic [7:0]       rx_byte,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             frame_kind,
  output logic [7:0]       pair_first,
  output logic [7:0]       pair_second,
  output logic [7:0]       text_char,
  output logic [POS_W-1:0] text_position,
  output logic             last_of_run
);

  q_push_t   qp;
  q_status_t qs;
  logic      pop;
  logic      accept;

  // stall on a full queue, ticks included, so no job is ever dropped
  assign item_stall = qs.full;
  assign accept     = item_valid && !item_stall;

  dpfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .qp        (qp)
  );

  dpfr_queue u_queue (
    .clk (clk),
    .rst (rst),
    .qp  (qp),
    .pop (pop),
    .qs  (qs)
  );

  dpfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .qs            (qs),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .frame_kind    (frame_kind),
    .pair_first    (pair_first),
    .pair_second   (pair_second),
    .text_char     (text_char),
    .text_position (text_position),
    .last_of_run   (last_of_run)
  );

endmodule

### tb/frame_result_checker.sv
// checker for the frame receiver: follows both channels, predicts the results and compares them
module frame_result_checker import dpfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [15:0]      cfg_data,
  input  logic             item_valid,
  input  logic             item_stall,
  input  logic             cmd,
  input  logic [7:0]       rx_byte,
  input  logic             result_valid,
  input  logic             result_stall,
  input  logic             frame_kind,
  input  logic [7:0]       pair_first,
  input  logic [7:0]       pair_second,
  input  logic [7:0]       text_char,
  input  logic [POS_W-1:0] text_position,
  input  logic             last_of_run,
  output int               fail_count,
  output int               outstanding
);

  typedef enum logic [2:0] {
    WAIT_HEADER = 3'd0,
    PAIR_BODY   = 3'd1,
    PAIR_FOOTER = 3'd2,
    TEXT_BODY   = 3'd3,
    TEXT_LF     = 3'd4
  } parse_state_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       first;
    logic [7:0]       second;
    logic [7:0]       ch;
    logic [POS_W-1:0] pos;
    logic             last;
  } frame_result_t;

  parse_state_t      parse_state;
  logic [POS_W-1:0]  fill_index;
  logic [7:0]        pair_bytes [PAIR_LENGTH];
  logic [7:0]        text_bytes [TEXT_DEPTH];
  logic [TICK_W-1:0] elapsed_ticks;
  logic [TICK_W-1:0] timeout_ticks;

  frame_result_t expected_results [$];
  frame_result_t seen, wanted;
  int            errors = 0;

  task automatic queue_result(input logic k, input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input logic [POS_W-1:0] p, input logic l);
    frame_result_t r;
    r.kind   = k;
    r.first  = a;
    r.second = b;
    r.ch     = c;
    r.pos    = p;
    r.last   = l;
    expected_results.push_back(r);
  endtask

  // one accepted beat through the frame parser
  task automatic predict_frame_results(input logic c, input logic [7:0] b);
    if (c == CMD_TICK) begin
      if (elapsed_ticks != {TICK_W{1'b1}}) elapsed_ticks = elapsed_ticks + 1'b1;
      if (parse_state != WAIT_HEADER && elapsed_ticks > timeout_ticks)
        parse_state = WAIT_HEADER;
    end else begin
      elapsed_ticks = '0;
      case (parse_state)
        PAIR_BODY: begin
          pair_bytes[fill_index] = b;
          fill_index = fill_index + 1'b1;
          if (fill_index >= PAIR_LENGTH) parse_state = PAIR_FOOTER;
        end
        PAIR_FOOTER: begin
          if (b == BIN_FOOTER)
            queue_result(KIND_PAIR, pair_bytes[0], pair_bytes[1], 8'd0, '0, 1'b1);
          parse_state = WAIT_HEADER;
        end
        TEXT_BODY: begin
          if (b == TXT_CR) begin
            parse_state = TEXT_LF;
          end else if (fill_index < TEXT_DEPTH) begin
            text_bytes[fill_index] = b;
            fill_index = fill_index + 1'b1;
          end
        end
        TEXT_LF: begin
          if (b == TXT_LF) begin
            for (int i = 0; i < fill_index; i++)
              queue_result(KIND_TEXT, 8'd0, 8'd0, text_bytes[i], POS_W'(i), 1'b0);
            queue_result(KIND_TEXT, 8'd0, 8'd0, 8'd0, fill_index, 1'b1);
          end
          parse_state = WAIT_HEADER;
        end
        default: begin
          parse_state = WAIT_HEADER;
          if (b == BIN_HEADER) begin
            parse_state = PAIR_BODY;
            fill_index  = '0;
          end else if (b == TXT_HEADER) begin
            parse_state = TEXT_BODY;
            fill_index  = '0;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_state   = WAIT_HEADER;
      fill_index    = '0;
      elapsed_ticks = '0;
      timeout_ticks = TIMEOUT_RESET;
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        seen = {frame_kind, pair_first, pair_second, text_char, text_position, last_of_run};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: kind %0d pair %02h %02h char %02h pos %0d last %0d",
                     seen.kind, seen.first, seen.second, seen.ch, seen.pos, seen.last);
        end else begin
          wanted = expected_results.pop_front();
          if (seen !== wanted) begin
            errors++;
            if (errors <= 10)
              $display({"result mismatch: expected kind %0d pair %02h %02h char %02h pos %0d",
                        " last %0d, got kind %0d pair %02h %02h char %02h pos %0d last %0d"},
                       wanted.kind, wanted.first, wanted.second, wanted.ch, wanted.pos,
                       wanted.last, seen.kind, seen.first, seen.second, seen.ch, seen.pos,
                       seen.last);
          end
        end
      end
      if (cfg_write) timeout_ticks = cfg_data;
      if (item_valid && !item_stall) predict_frame_results(cmd, rx_byte);
    end
    outstanding <= expected_results.size();
    fail_count  <= errors;
  end

endmodule

### tb/dual_protocol_frame_receiver_tb.sv
// stimulus and verdict for the dual protocol frame receiver
module dual_protocol_frame_receiver_tb;
  import dpfr_pkg::*;

  // cycles with no beat on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // settling time once the last result is in: the job queue may still hold
  // character stores that cause no result
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_BEATS    = 45;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             cfg_write    = 1'b0;
  logic [15:0]      cfg_data     = '0;
  logic             item_valid   = 1'b0;
  logic             item_stall;
  logic             cmd          = CMD_BYTE;
  logic [7:0]       rx_byte      = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic             frame_kind;
  logic [7:0]       pair_first;
  logic [7:0]       pair_second;
  logic [7:0]       text_char;
  logic [POS_W-1:0] text_position;
  logic             last_of_run;

  int fail_count;
  int outstanding;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int frame_beats   = 0;
  logic [15:0] timeout_now = TIMEOUT_RESET;

  always #6 clk = ~clk;

  dual_protocol_frame_receiver DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .frame_kind    (frame_kind),
    .pair_first    (pair_first),
    .pair_second   (pair_second),
    .text_char     (text_char),
    .text_position (text_position),
    .last_of_run   (last_of_run)
  );

  frame_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .frame_kind    (frame_kind),
    .pair_first    (pair_first),
    .pair_second   (pair_second),
    .text_char     (text_char),
    .text_position (text_position),
    .last_of_run   (last_of_run),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // receiver back-pressure, redrawn every cycle at the current phase's rate
  always @(posedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // hang detection: any beat on either channel restarts the count
  always @(posedge clk) begin
    if (!rst && ((item_valid && !item_stall) || (result_valid && !result_stall)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[dual_protocol_frame_receiver] ERROR");
      $finish;
    end
  end

  // one beat on the item channel; an idle gap may come first, and valid stays
  // high straight into the next beat when there is none
  task automatic send_beat(input logic c, input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    cmd        <= c;
    rx_byte    <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // tick beats carry a random byte that the block must ignore
  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++) send_beat(CMD_TICK, 8'($urandom_range(255)));
  endtask

  // frame byte, now and then preceded by a tick or two so short timeouts fire
  task automatic frame_byte(input logic [7:0] b);
    if ($urandom_range(9) == 0) send_ticks($urandom_range(1, 2));
    send_beat(CMD_BYTE, b);
    frame_beats++;
  endtask

  // hold the sender off until every predicted result has been taken
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // timeout register is only touched once the block has gone quiet
  task automatic set_timeout(input logic [15:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write   <= 1'b1;
    cfg_data    <= value;
    timeout_now = value;
    @(posedge clk);
    cfg_write   <= 1'b0;
  endtask

  function automatic logic [7:0] text_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == TXT_CR);
    return b;
  endfunction

  // one random frame, well formed most of the time
  task automatic random_frame();
    int pick;
    int len;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 35) begin
      // good pair frame
      frame_byte(BIN_HEADER);
      frame_byte(8'($urandom_range(255)));
      frame_byte(8'($urandom_range(255)));
      frame_byte(BIN_FOOTER);
    end else if (pick < 65) begin
      // good text frame, now and then long enough to overflow the store
      len = ($urandom_range(9) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 6);
      frame_byte(TXT_HEADER);
      for (int i = 0; i < len; i++) frame_byte(text_body_byte());
      frame_byte(TXT_CR);
      frame_byte(TXT_LF);
    end else if (pick < 75) begin
      // pair frame with a wrong footer
      frame_byte(BIN_HEADER);
      frame_byte(8'($urandom_range(255)));
      frame_byte(8'($urandom_range(255)));
      do b = 8'($urandom_range(255)); while (b == BIN_FOOTER);
      frame_byte(b);
    end else if (pick < 83) begin
      // text frame with something other than a line feed after the return
      len = $urandom_range(0, 4);
      frame_byte(TXT_HEADER);
      for (int i = 0; i < len; i++) frame_byte(text_body_byte());
      frame_byte(TXT_CR);
      do b = 8'($urandom_range(255)); while (b == TXT_LF);
      frame_byte(b);
    end else if (pick < 91) begin
      // tick run in the middle of a frame, around the timeout when that is short
      if ($urandom_range(1) == 0) begin
        frame_byte(BIN_HEADER);
        frame_byte(8'($urandom_range(255)));
      end else begin
        frame_byte(TXT_HEADER);
        frame_byte(text_body_byte());
      end
      if (timeout_now <= 8) send_ticks(timeout_now + $urandom_range(0, 1));
      else send_ticks($urandom_range(1, 3));
      frame_byte(8'($urandom_range(255)));
      frame_byte(TXT_CR);
      frame_byte(($urandom_range(1) == 0) ? TXT_LF : BIN_FOOTER);
    end else begin
      // idle noise, not counted as frame traffic
      if ($urandom_range(1) == 0) send_ticks(1);
      else send_beat(CMD_BYTE, 8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input logic [15:0] timeout, input int send_pct, input int stall_rate);
    int frames;
    set_timeout(timeout);
    send_idle_pct = send_pct;
    stall_pct     <= stall_rate;
    frames        = 0;
    frame_beats   = 0;
    while (frame_beats < PHASE_BEATS) begin
      random_frame();
      frames++;
      // let the result side catch up completely once per phase
      if (frames == 8) wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset timeout: header values as payload, bad
    // footer, empty text frame, bad line feed, idle noise and idle ticks
    send_beat(CMD_BYTE, BIN_HEADER);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, BIN_HEADER);
    send_beat(CMD_BYTE, BIN_FOOTER);
    send_beat(CMD_BYTE, BIN_HEADER);
    send_beat(CMD_BYTE, BIN_HEADER);
    send_beat(CMD_BYTE, 8'h80);
    send_beat(CMD_BYTE, 8'h7F);
    send_beat(CMD_BYTE, TXT_HEADER);
    send_beat(CMD_BYTE, TXT_HEADER);
    send_beat(CMD_BYTE, BIN_HEADER);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, TXT_CR);
    send_beat(CMD_BYTE, TXT_LF);
    send_beat(CMD_BYTE, TXT_HEADER);
    send_beat(CMD_BYTE, TXT_CR);
    send_beat(CMD_BYTE, TXT_LF);
    send_beat(CMD_BYTE, TXT_HEADER);
    send_beat(CMD_BYTE, 8'h78);
    send_beat(CMD_BYTE, TXT_CR);
    send_beat(CMD_BYTE, 8'h79);
    send_beat(CMD_BYTE, 8'h55);
    send_beat(CMD_TICK, 8'hFF);
    send_beat(CMD_BYTE, BIN_FOOTER);
    send_beat(CMD_BYTE, TXT_LF);

    // text frame past the store's capacity: the extra characters are dropped
    // and the drain gives the longest run of results
    send_beat(CMD_BYTE, TXT_HEADER);
    for (int i = 0; i < 66; i++) send_beat(CMD_BYTE, 8'(8'h41 + i));
    send_beat(CMD_BYTE, TXT_CR);
    send_beat(CMD_BYTE, TXT_LF);

    // random phases: shortest timeout with no idling, longest with a slow
    // sender, a stalling receiver, then both idling together
    run_phase(16'd1,     0,  0);
    run_phase(16'd65534, 63, 0);
    run_phase(16'd3,     0,  63);
    run_phase(16'd100,   24, 24);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // the checker's count settles at the rising edge, so read it at the falling edge
    @(negedge clk);
    if (fail_count == 0)
      $display("[dual_protocol_frame_receiver] OK");
    else
      $display("[dual_protocol_frame_receiver] ERROR");
    $finish;
  end

endmodule
